/* rtl/core/plwt_pkg.sv */
package plwt_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WL_W       = 16;
  localparam int AMP_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = AMP_W + FRAC_W + 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     operation;
    logic [IDX_W-1:0]        point_index;
    logic [WL_W-1:0]         wavelength;
    logic signed [AMP_W-1:0] amplitude;
  } in_item_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] curve_value;
    logic                    inside_res;
  } out_item_t;

  typedef struct packed {
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [WL_W-1:0]         wr_wl;
    logic signed [AMP_W-1:0] wr_amp;
    logic [IDX_W-1:0]        rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [WL_W-1:0]         wl;
    logic signed [AMP_W-1:0] amp;
  } mem_rsp_t;

  typedef struct packed {
    logic              start;
    logic [WL_W-1:0]   num;
    logic [WL_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctrl_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SEARCH,
    ST_LOW,
    ST_HIGH,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } plwt_state_t;

endpackage

/* rtl/core/piecewise_linear_table_eval.sv */
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall   in_item (in_item_t)
// out_     output     out_valid/out_stall out_item (out_item_t)
// cfg_     input      cfg_valid/cfg_ready cfg_point_count (7 bits)
//
// A load is written to the table as it is accepted and leaves the block free for the next item;
// an evaluate runs a binary search (up to 6 search steps at 64 points), dependent table reads
// and the bit-serial divider. Too few points or a query out of range go straight to the result;
// a query on a breakpoint or past its segment end skips the divider.
// Synchronous active-low reset clears control and point_count; table contents stay.
// A result held by out_stall waits in the output register while the next item runs.
module piecewise_linear_table_eval
  import plwt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_point_count
);

  logic [CNT_W-1:0] point_count_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             res_ready;
  mem_req_t         mem_req;
  mem_rsp_t         mem_rsp;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  ctrl_stat_t       stat;
  out_item_t        res;

  assign in_stall  = stat.busy || !rst_n;
  assign cfg_ready = !stat.busy && rst_n;
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      point_count_r <= cfg_point_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && stat.res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  plwt_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  plwt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  plwt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .point_count (point_count_r),
    .mem_req     (mem_req),
    .mem_rsp     (mem_rsp),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .res_ready   (res_ready),
    .stat        (stat),
    .res         (res)
  );

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.operation == OP_LOAD) |=> !in_stall)
    else $error("load item did not complete in one cycle");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.operation == OP_EVAL) |=> stat.busy)
    else $error("evaluate item did not start work");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_valid && !res.inside_res) |-> (res.curve_value == '0))
    else $error("out-of-range result carries nonzero value");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> stat.busy)
    else $error("divider started while controller idle");

endmodule

/* rtl/core/plwt_mem.sv */
module plwt_mem
  import plwt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mem_req,
  output mem_rsp_t mem_rsp
);

  logic [WL_W-1:0]         wl_mem  [MAX_POINTS];
  logic signed [AMP_W-1:0] amp_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      wl_mem[mem_req.wr_addr]  <= mem_req.wr_wl;
      amp_mem[mem_req.wr_addr] <= mem_req.wr_amp;
    end
  end

  always_ff @(posedge clk) begin
    mem_rsp.wl  <= wl_mem[mem_req.rd_addr];
    mem_rsp.amp <= amp_mem[mem_req.rd_addr];
  end

endmodule

/* rtl/core/plwt_div.sv */
module plwt_div
  import plwt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  localparam int STEP_W = $clog2(FRAC_W + 1);

  logic [WL_W-1:0]     rem_r;
  logic [WL_W-1:0]     den_r;
  logic [FRAC_W-1:0]   quot_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  logic                done_r;
  logic [WL_W:0]       rem_sh;
  logic                fits;

  // restoring division, one quotient bit per cycle; num < den so rem stays below 2^16
  assign rem_sh = {rem_r, 1'b0};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(FRAC_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem_r  <= div_req.num;
      den_r  <= div_req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? WL_W'(rem_sh - {1'b0, den_r}) : rem_sh[WL_W-1:0];
      quot_r <= {quot_r[FRAC_W-2:0], fits};
    end
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quot = quot_r;

endmodule

/* rtl/core/plwt_ctrl.sv */
module plwt_ctrl
  import plwt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_item_t         in_item,
  input  logic [CNT_W-1:0] point_count,
  output mem_req_t         mem_req,
  input  mem_rsp_t         mem_rsp,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  input  logic             res_ready,
  output ctrl_stat_t       stat,
  output out_item_t        res
);

  plwt_state_t             state_r, state_nxt;
  logic [WL_W-1:0]         q_r;
  logic [CNT_W-1:0]        n_r;
  logic [IDX_W-1:0]        first_r, size_r, o_r;
  logic [WL_W-1:0]         wl_o_r;
  logic signed [AMP_W-1:0] amp_a_r;
  logic signed [AMP_W:0]   diff_r;
  logic signed [PROD_W-1:0] prod_r;
  out_item_t               res_r;

  logic                    accept, is_eval;
  logic [CNT_W-1:0]        n_in;
  logic [IDX_W-1:0]        size_init;
  logic [IDX_W-1:0]        half, mid, first_s, size_s;
  logic                    go_up;
  logic signed [WL_W:0]    d, span;
  logic                    d_le0, d_ge_span, no_div;

  assign accept  = in_valid && rst_n && (state_r == ST_IDLE);
  assign is_eval = (in_item.operation == OP_EVAL);
  assign n_in    = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;

  // search over indices 1..n-2 for the largest breakpoint not above the query
  assign size_init = IDX_W'(n_r - CNT_W'(2));
  assign half      = size_r >> 1;
  assign mid       = first_r + half;
  assign go_up     = mem_rsp.wl <= q_r;
  assign first_s   = go_up ? mid + IDX_W'(1) : first_r;
  assign size_s    = go_up ? size_r - half - IDX_W'(1) : half;

  assign d         = $signed({1'b0, q_r}) - $signed({1'b0, wl_o_r});
  assign span      = $signed({1'b0, mem_rsp.wl}) - $signed({1'b0, wl_o_r});
  assign d_le0     = d[WL_W] || (d == '0);
  assign d_ge_span = d >= span;
  assign no_div    = d_le0 || d_ge_span;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_eval) begin
          state_nxt = (n_in < CNT_W'(2)) ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST:  state_nxt = (q_r < mem_rsp.wl) ? ST_DONE : ST_LAST;
      ST_LAST: begin
        if (q_r > mem_rsp.wl) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = (n_r == CNT_W'(2)) ? ST_LOW : ST_SEARCH;
        end
      end
      ST_SEARCH: state_nxt = (size_s == '0) ? ST_LOW : ST_SEARCH;
      ST_LOW:    state_nxt = ST_HIGH;
      ST_HIGH:   state_nxt = no_div ? ST_DONE : ST_DIV;
      ST_DIV:    state_nxt = div_rsp.done ? ST_SUM : ST_DIV;
      ST_SUM:    state_nxt = ST_DONE;
      ST_DONE:   state_nxt = res_ready ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req.wr_en   = accept && !is_eval;
    mem_req.wr_addr = in_item.point_index;
    mem_req.wr_wl   = in_item.wavelength;
    mem_req.wr_amp  = in_item.amplitude;
    mem_req.rd_addr = '0;
    unique case (state_r)
      ST_FIRST: mem_req.rd_addr = IDX_W'(n_r - CNT_W'(1));
      ST_LAST: begin
        mem_req.rd_addr = (n_r == CNT_W'(2)) ? '0 : IDX_W'(1) + (size_init >> 1);
      end
      ST_SEARCH: begin
        mem_req.rd_addr = (size_s == '0) ? first_s - IDX_W'(1) : first_s + (size_s >> 1);
      end
      ST_LOW:   mem_req.rd_addr = o_r + IDX_W'(1);
      default:  mem_req.rd_addr = '0;
    endcase

    div_req.start = (state_r == ST_HIGH) && !no_div;
    div_req.num   = d[WL_W-1:0];
    div_req.den   = span[WL_W-1:0];

    stat.busy      = (state_r != ST_IDLE);
    stat.res_valid = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_eval) begin
          q_r   <= in_item.wavelength;
          n_r   <= n_in;
          res_r <= '0;
        end
      end
      ST_LAST: begin
        first_r <= IDX_W'(1);
        size_r  <= size_init;
        o_r     <= '0;
      end
      ST_SEARCH: begin
        first_r <= first_s;
        size_r  <= size_s;
        o_r     <= first_s - IDX_W'(1);
      end
      ST_LOW: begin
        wl_o_r  <= mem_rsp.wl;
        amp_a_r <= mem_rsp.amp;
      end
      ST_HIGH: begin
        if (d_le0) begin
          res_r <= '{curve_value: amp_a_r, inside_res: 1'b1};
        end else if (d_ge_span) begin
          res_r <= '{curve_value: mem_rsp.amp, inside_res: 1'b1};
        end else begin
          diff_r <= $signed({mem_rsp.amp[AMP_W-1], mem_rsp.amp})
                  - $signed({amp_a_r[AMP_W-1], amp_a_r});
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          prod_r <= $signed({1'b0, div_rsp.quot}) * diff_r;
        end
      end
      ST_SUM: begin
        // arithmetic shift by 16 floors toward minus infinity
        res_r.curve_value <= amp_a_r + prod_r[AMP_W+FRAC_W-1:FRAC_W];
        res_r.inside_res  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

endmodule
